[hdl/ffha_pkg.sv]
// Shared types, datapath command codes and status codes for the heap allocator.
package ffha_pkg;

    localparam int OFF_W  = 20;
    localparam int SIZE_W = 21;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic [4:0] OP_IDLE      = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_SET_ST    = 5'd2;
    localparam logic [4:0] OP_SCAN_RD   = 5'd3;
    localparam logic [4:0] OP_SCAN_NEXT = 5'd4;
    localparam logic [4:0] OP_HIT       = 5'd5;
    localparam logic [4:0] OP_TAKE      = 5'd6;
    localparam logic [4:0] OP_SHUP_RD   = 5'd7;
    localparam logic [4:0] OP_SHUP_WR   = 5'd8;
    localparam logic [4:0] OP_SPL_W1    = 5'd9;
    localparam logic [4:0] OP_SPL_W0    = 5'd10;
    localparam logic [4:0] OP_NXT_RD    = 5'd11;
    localparam logic [4:0] OP_NXT_CAP   = 5'd12;
    localparam logic [4:0] OP_MERGE     = 5'd13;
    localparam logic [4:0] OP_SHDN_RD   = 5'd14;
    localparam logic [4:0] OP_SHDN_WR   = 5'd15;
    localparam logic [4:0] OP_SHDN_END  = 5'd16;
    localparam logic [4:0] OP_PUBLISH   = 5'd17;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] bytes;
        logic              free;
    } t_seg;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] st;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic null_free;
        logic scan_end;
        logic hit;
        logic split;
        logic full;
        logic has_next;
        logic need_shift;
        logic shup_more;
        logic shdn_more;
        logic out_busy;
    } t_dp_stat;

endpackage

[hdl/ffha_dp.sv]
// Datapath: segment table memory, scan pointers, arithmetic and result register.
module ffha_dp #(
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffha_pkg::t_dp_cmd             i_cmd_bus,
    output ffha_pkg::t_dp_stat            o_stat,
    input  logic                          i_cmd,
    input  logic [ffha_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffha_pkg::OFF_W-1:0]    i_free_offset,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [ffha_pkg::OFF_W-1:0]    o_payload_offset
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [6:0] HDR = 7'(HEADER_BYTES);
    localparam logic [ffha_pkg::SIZE_W-1:0] INIT_BYTES =
        ffha_pkg::SIZE_W'(HEAP_BYTES - HEADER_BYTES);

    ffha_pkg::t_seg mem [MAX_SEGMENTS];

    ffha_pkg::t_seg r_rdat, r_hold, r_prev;
    logic                          r_cmd;
    logic [ffha_pkg::SIZE_W-1:0]   r_size;
    logic [ffha_pkg::OFF_W-1:0]    r_off;
    logic [CW-1:0]                 r_cnt, r_idx, r_p;
    logic [1:0]                    r_d;
    logic                          r_pf, r_nf;
    logic [ffha_pkg::SIZE_W-1:0]   r_nbytes;
    logic [1:0]                    r_st;
    logic [ffha_pkg::OFF_W-1:0]    r_poff;
    logic                          r_ovalid;
    logic [1:0]                    r_ostatus;
    logic [ffha_pkg::OFF_W-1:0]    r_opoff;

    logic [4:0]                    op;
    logic                          we, re;
    logic [AW-1:0]                 wa, ra;
    ffha_pkg::t_seg                wd;
    logic [CW:0]                   idx_p1, p_pd;
    logic [ffha_pkg::SIZE_W:0]     need_sz;
    logic [ffha_pkg::SIZE_W-1:0]   nadd;

    assign op      = i_cmd_bus.op;
    assign idx_p1  = {1'b0, r_idx} + (CW+1)'(1);
    assign p_pd    = {1'b0, r_p} + (CW+1)'(r_d);
    assign need_sz = {1'b0, r_size} + (ffha_pkg::SIZE_W+1)'(HDR);
    assign nadd    = r_nf ? (r_nbytes + ffha_pkg::SIZE_W'(HDR)) : '0;

    always_comb begin
        o_stat.is_free    = (r_cmd == ffha_pkg::CMD_FREE);
        o_stat.null_free  = (r_cmd == ffha_pkg::CMD_FREE) && (r_off == '0);
        o_stat.scan_end   = (r_idx >= r_cnt);
        if (r_cmd == ffha_pkg::CMD_FREE) begin
            o_stat.hit = !r_rdat.free &&
                (({1'b0, r_rdat.start} + (ffha_pkg::OFF_W+1)'(HDR)) == {1'b0, r_off});
        end else begin
            o_stat.hit = r_rdat.free && (r_rdat.bytes >= r_size);
        end
        o_stat.split      = ({1'b0, r_rdat.bytes} > need_sz);
        o_stat.full       = (r_cnt >= CW'(MAX_SEGMENTS));
        o_stat.has_next   = (idx_p1 < {1'b0, r_cnt});
        o_stat.need_shift = r_pf || r_nf;
        o_stat.shup_more  = ({1'b0, r_p} > idx_p1);
        o_stat.shdn_more  = (p_pd < {1'b0, r_cnt});
        o_stat.out_busy   = r_ovalid && !i_ready;
    end

    always_comb begin
        we = 1'b0;
        re = 1'b0;
        wa = r_idx[AW-1:0];
        ra = r_idx[AW-1:0];
        wd = r_hold;
        unique case (op)
            ffha_pkg::OP_SCAN_RD: re = 1'b1;
            ffha_pkg::OP_NXT_RD: begin
                re = 1'b1;
                ra = idx_p1[AW-1:0];
            end
            ffha_pkg::OP_SHUP_RD: begin
                re = 1'b1;
                ra = AW'(r_p - CW'(1));
            end
            ffha_pkg::OP_SHDN_RD: begin
                re = 1'b1;
                ra = p_pd[AW-1:0];
            end
            ffha_pkg::OP_TAKE: begin
                we = 1'b1;
                wd = '{start: r_hold.start, bytes: r_hold.bytes, free: 1'b0};
            end
            ffha_pkg::OP_SHUP_WR, ffha_pkg::OP_SHDN_WR: begin
                we = 1'b1;
                wa = r_p[AW-1:0];
                wd = r_rdat;
            end
            ffha_pkg::OP_SPL_W1: begin
                we = 1'b1;
                wa = idx_p1[AW-1:0];
                wd.start = r_hold.start + ffha_pkg::OFF_W'(HDR) + r_size[ffha_pkg::OFF_W-1:0];
                wd.bytes = r_hold.bytes - r_size - ffha_pkg::SIZE_W'(HDR);
                wd.free  = 1'b1;
            end
            ffha_pkg::OP_SPL_W0: begin
                we = 1'b1;
                wd = '{start: r_hold.start, bytes: r_size, free: 1'b0};
            end
            ffha_pkg::OP_MERGE: begin
                we = 1'b1;
                if (r_pf) begin
                    wa = AW'(r_idx - CW'(1));
                    wd.start = r_prev.start;
                    wd.bytes = r_prev.bytes + r_hold.bytes + ffha_pkg::SIZE_W'(HDR) + nadd;
                end else begin
                    wd.start = r_hold.start;
                    wd.bytes = r_hold.bytes + nadd;
                end
                wd.free = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            mem[0] <= '{start: '0, bytes: INIT_BYTES, free: 1'b1};
        end else if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rdat <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= CW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (op == ffha_pkg::OP_PUBLISH) || (r_ovalid && !i_ready);
            unique case (op)
                ffha_pkg::OP_LOAD: begin
                    r_cmd  <= i_cmd;
                    r_size <= i_req_size;
                    r_off  <= i_free_offset;
                    r_idx  <= '0;
                    r_pf   <= 1'b0;
                    r_nf   <= 1'b0;
                    r_st   <= ffha_pkg::ST_OK;
                    r_poff <= '0;
                end
                ffha_pkg::OP_SET_ST: r_st <= i_cmd_bus.st;
                ffha_pkg::OP_SCAN_NEXT: begin
                    r_prev <= r_rdat;
                    r_pf   <= r_rdat.free;
                    r_idx  <= r_idx + CW'(1);
                end
                ffha_pkg::OP_HIT: begin
                    r_hold <= r_rdat;
                    r_p    <= r_cnt;
                    r_nf   <= 1'b0;
                    if (r_cmd == ffha_pkg::CMD_ALLOC) begin
                        r_poff <= r_rdat.start + ffha_pkg::OFF_W'(HDR);
                    end
                end
                ffha_pkg::OP_SHUP_WR: r_p <= r_p - CW'(1);
                ffha_pkg::OP_SPL_W0: r_cnt <= r_cnt + CW'(1);
                ffha_pkg::OP_NXT_CAP: begin
                    r_nf     <= r_rdat.free;
                    r_nbytes <= r_rdat.bytes;
                end
                ffha_pkg::OP_MERGE: begin
                    if (r_pf) begin
                        r_p <= r_idx;
                        r_d <= r_nf ? 2'd2 : 2'd1;
                    end else begin
                        r_p <= CW'(idx_p1);
                        r_d <= 2'd1;
                    end
                end
                ffha_pkg::OP_SHDN_WR: r_p <= r_p + CW'(1);
                ffha_pkg::OP_SHDN_END: r_cnt <= r_cnt - CW'(r_d);
                ffha_pkg::OP_PUBLISH: begin
                    r_ostatus <= r_st;
                    r_opoff   <= r_poff;
                end
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_payload_offset = r_opoff;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= CW'(MAX_SEGMENTS)))
        else $error("segment count out of range");
    a_pub_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == ffha_pkg::OP_PUBLISH) |-> !(r_ovalid && !i_ready))
        else $error("result overwritten before taken");
    a_split_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == ffha_pkg::OP_SPL_W0) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("split did not grow table");
    a_merge_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == ffha_pkg::OP_SHDN_END) |=> (r_cnt < $past(r_cnt)))
        else $error("merge did not shrink table");

endmodule

[hdl/ffha_ctrl.sv]
// Controller: sequences scan, split, merge and table shifts for one request.
module ffha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ffha_pkg::t_dp_stat  i_stat,
    output ffha_pkg::t_dp_cmd   o_cmd_bus
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_TAKE     = 4'd4;
    localparam logic [3:0] S_SHUP_RD  = 4'd5;
    localparam logic [3:0] S_SHUP_WR  = 4'd6;
    localparam logic [3:0] S_SPL_W1   = 4'd7;
    localparam logic [3:0] S_SPL_W0   = 4'd8;
    localparam logic [3:0] S_NXT_RD   = 4'd9;
    localparam logic [3:0] S_NXT_CAP  = 4'd10;
    localparam logic [3:0] S_MERGE    = 4'd11;
    localparam logic [3:0] S_SHDN_RD  = 4'd12;
    localparam logic [3:0] S_SHDN_WR  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd_bus.op = ffha_pkg::OP_IDLE;
        o_cmd_bus.st = ffha_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd_bus.op = ffha_pkg::OP_LOAD;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: n_state = i_stat.null_free ? S_DONE : S_SCAN_RD;
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd_bus.op = ffha_pkg::OP_SET_ST;
                    o_cmd_bus.st = i_stat.is_free ? ffha_pkg::ST_BADFREE : ffha_pkg::ST_NOFIT;
                    n_state      = S_DONE;
                end else begin
                    o_cmd_bus.op = ffha_pkg::OP_SCAN_RD;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                priority if (!i_stat.hit) begin
                    o_cmd_bus.op = ffha_pkg::OP_SCAN_NEXT;
                    n_state      = S_SCAN_RD;
                end else if (i_stat.is_free) begin
                    o_cmd_bus.op = ffha_pkg::OP_HIT;
                    n_state      = S_NXT_RD;
                end else if (i_stat.split && i_stat.full) begin
                    o_cmd_bus.op = ffha_pkg::OP_SET_ST;
                    o_cmd_bus.st = ffha_pkg::ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    o_cmd_bus.op = ffha_pkg::OP_HIT;
                    n_state      = i_stat.split ? S_SHUP_RD : S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd_bus.op = ffha_pkg::OP_TAKE;
                n_state      = S_DONE;
            end
            S_SHUP_RD: begin
                if (i_stat.shup_more) begin
                    o_cmd_bus.op = ffha_pkg::OP_SHUP_RD;
                    n_state      = S_SHUP_WR;
                end else begin
                    n_state = S_SPL_W1;
                end
            end
            S_SHUP_WR: begin
                o_cmd_bus.op = ffha_pkg::OP_SHUP_WR;
                n_state      = S_SHUP_RD;
            end
            S_SPL_W1: begin
                o_cmd_bus.op = ffha_pkg::OP_SPL_W1;
                n_state      = S_SPL_W0;
            end
            S_SPL_W0: begin
                o_cmd_bus.op = ffha_pkg::OP_SPL_W0;
                n_state      = S_DONE;
            end
            S_NXT_RD: begin
                if (i_stat.has_next) begin
                    o_cmd_bus.op = ffha_pkg::OP_NXT_RD;
                    n_state      = S_NXT_CAP;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_NXT_CAP: begin
                o_cmd_bus.op = ffha_pkg::OP_NXT_CAP;
                n_state      = S_MERGE;
            end
            S_MERGE: begin
                o_cmd_bus.op = ffha_pkg::OP_MERGE;
                n_state      = i_stat.need_shift ? S_SHDN_RD : S_DONE;
            end
            S_SHDN_RD: begin
                if (i_stat.shdn_more) begin
                    o_cmd_bus.op = ffha_pkg::OP_SHDN_RD;
                    n_state      = S_SHDN_WR;
                end else begin
                    o_cmd_bus.op = ffha_pkg::OP_SHDN_END;
                    n_state      = S_DONE;
                end
            end
            S_SHDN_WR: begin
                o_cmd_bus.op = ffha_pkg::OP_SHDN_WR;
                n_state      = S_SHDN_RD;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd_bus.op = ffha_pkg::OP_PUBLISH;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

[hdl/first_fit_heap_allocator.sv]
// Each request is decoded, then the table is scanned entry by entry (read, then check);
// a split moves later entries up and a merge moves them down (read, then write per entry),
// followed by the final writes and publish. One request at a time; ready returns when
// the result enters the output register, which holds while the result waits.
// Synchronous active-low reset: table holds one free segment of heap minus header.
// Top level: first-fit heap allocator with split and coalesce.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_cmd,
    input  logic [ffha_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [ffha_pkg::OFF_W-1:0]   i_free_offset,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [ffha_pkg::OFF_W-1:0]   o_payload_offset
);

    ffha_pkg::t_dp_cmd  cmd_bus;
    ffha_pkg::t_dp_stat stat;

    ffha_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_stat    (stat),
        .o_cmd_bus (cmd_bus)
    );

    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_bus        (cmd_bus),
        .o_stat           (stat),
        .i_cmd            (i_cmd),
        .i_req_size       (i_req_size),
        .i_free_offset    (i_free_offset),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

endmodule
